FILE: src/osah_pkg.sv
// ----------------------------------------------------------------------------
// osah_pkg: shared definitions for the online-softmax attention head
// Operation codes, configuration indexes, fixed-point constants and the
// queue entry that travels from the front end to the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

package osah_pkg;

  // Command codes as they arrive on the input port.
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_LOAD_Q  = 3'd1;
  localparam logic [2:0] CMD_LOAD_KV = 3'd2;
  localparam logic [2:0] CMD_TILE    = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;

  // Operation codes after classification; dropped commands become OP_NOP.
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_LOAD_Q  = 3'd1;
  localparam logic [2:0] OP_LOAD_KV = 3'd2;
  localparam logic [2:0] OP_TILE    = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_NOP     = 3'd7;

  // Configuration register indexes.
  localparam logic REG_TILE_COUNT  = 1'b0;
  localparam logic REG_LAST_TOKENS = 1'b1;

  localparam int HEAD_SIZE_DEF   = 128;
  localparam int TILE_TOKENS_DEF = 16;

  localparam int CFG_W  = 11;
  localparam int TC_W   = 11;
  localparam int LT_W   = 5;
  localparam int CNT_W  = 7;

  // round(2^24 / sqrt(128))
  localparam int SCALE_Q24 = 1482910;
  // exp() is zero at or below -16.0 in Q.16
  localparam logic signed [32:0] EXP_FLOOR = -33'sd1048576;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         op;
    logic [6:0]         dim;
    logic [3:0]         tok;
    logic signed [15:0] q;
    logic signed [15:0] k;
    logic signed [15:0] v;
    logic [CNT_W-1:0]   cnt;
    logic               dim_ok;
  } osah_entry_t;

endpackage

`default_nettype wire

FILE: src/online_softmax_attention_head_top.sv
// ----------------------------------------------------------------------------
// online_softmax_attention_head_top: single-head attention, online softmax
// Loads one query and one tile of key/value rows, folds tiles into a running
// softmax-weighted accumulator and returns normalised output elements.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------------
//  input     start / busy            in_command, in_dim_index, in_token_index,
//                                    in_q_elem, in_k_elem, in_v_elem,
//                                    in_tile_index
//  result    out_strobe (one cycle)  out_elem, out_dim
//  config    cfg_we                  cfg_index, cfg_wdata
//
// A transaction is taken when start is high and busy is low; a four-entry
// queue sits between intake and execution, so busy only rises when it fills.
// Clear and load transactions are carried out straight from the idle state.
// A tile walks the key/value memory element by element, once to score each
// token and once to fold its weighted values into the accumulator.
// A read runs the one-bit-per-cycle divider; an empty sum or an
// out-of-range dimension returns straight from the idle state without dividing.
// Reset is synchronous and active low; it empties the queue and clears the
// accumulator valid bits, running maximum and running sum at once.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module online_softmax_attention_head_top #(
  parameter int HEAD_SIZE   = osah_pkg::HEAD_SIZE_DEF,
  parameter int TILE_TOKENS = osah_pkg::TILE_TOKENS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 in_command,
  input  wire logic [6:0]                 in_dim_index,
  input  wire logic [3:0]                 in_token_index,
  input  wire logic signed [15:0]         in_q_elem,
  input  wire logic signed [15:0]         in_k_elem,
  input  wire logic signed [15:0]         in_v_elem,
  input  wire logic [9:0]                 in_tile_index,
  input  wire logic                       cfg_we,
  input  wire logic [0:0]                 cfg_index,
  input  wire logic [osah_pkg::CFG_W-1:0] cfg_wdata,
  output logic                            out_strobe,
  output logic signed [15:0]              out_elem,
  output logic [6:0]                      out_dim
);

  // The front end classifies each transaction (dropping unknown commands and
  // out-of-range loads, and working out the tile's valid token count) and
  // queues it; the back end pops one operation at a time.
  osah_pkg::osah_entry_t entry;
  logic                  entry_valid;
  logic                  entry_pop;

  osah_front #(
    .HEAD_SIZE   (HEAD_SIZE),
    .TILE_TOKENS (TILE_TOKENS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_dim_index   (in_dim_index),
    .in_token_index (in_token_index),
    .in_q_elem      (in_q_elem),
    .in_k_elem      (in_k_elem),
    .in_v_elem      (in_v_elem),
    .in_tile_index  (in_tile_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .entry          (entry),
    .entry_valid    (entry_valid),
    .entry_pop      (entry_pop)
  );

  // The back end holds all the memories and the arithmetic: scoring,
  // running-maximum tracking, rescaling, accumulation and the final divide.
  osah_back #(
    .HEAD_SIZE   (HEAD_SIZE),
    .TILE_TOKENS (TILE_TOKENS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry       (entry),
    .entry_valid (entry_valid),
    .entry_pop   (entry_pop),
    .out_strobe  (out_strobe),
    .out_elem    (out_elem),
    .out_dim     (out_dim)
  );

endmodule

`default_nettype wire

FILE: src/osah_exp.sv
// ----------------------------------------------------------------------------
// osah_exp: iterative fixed-point exponential
// Computes (1 + x/64)^64 in Q.16 for x <= 0 by six squarings, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osah_exp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [32:0] x,
  output logic                    done,
  output logic [16:0]             y
);

  logic              busy_r;
  logic              done_r;
  logic [2:0]        it_r;
  logic [16:0]       y_r;
  logic signed [32:0] xc;
  logic signed [32:0] y0;
  logic [33:0]       sq;

  always_comb begin
    xc = (x > 33'sd0) ? 33'sd0 : x;
    y0 = 33'sd65536 + (xc >>> 6);
    sq = 34'(y_r) * 34'(y_r) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (x <= osah_pkg::EXP_FLOOR) begin
          y_r    <= '0;
          done_r <= 1'b1;
        end else begin
          y_r    <= y0[16:0];
          it_r   <= 3'd6;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        y_r  <= sq[32:16];
        it_r <= it_r - 3'd1;
        if (it_r == 3'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

`default_nettype wire

FILE: src/osah_front.sv
// ----------------------------------------------------------------------------
// osah_front: command intake and classification
// Holds the configuration registers, turns each command into an operation
// with its valid token count and queues it for the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module osah_front #(
  parameter int HEAD_SIZE   = osah_pkg::HEAD_SIZE_DEF,
  parameter int TILE_TOKENS = osah_pkg::TILE_TOKENS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                in_command,
  input  wire logic [6:0]                in_dim_index,
  input  wire logic [3:0]                in_token_index,
  input  wire logic signed [15:0]        in_q_elem,
  input  wire logic signed [15:0]        in_k_elem,
  input  wire logic signed [15:0]        in_v_elem,
  input  wire logic [9:0]                in_tile_index,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [osah_pkg::CFG_W-1:0] cfg_wdata,
  output osah_pkg::osah_entry_t          entry,
  output logic                           entry_valid,
  input  wire logic                      entry_pop
);

  localparam int DEPTH = 4;

  logic [osah_pkg::TC_W-1:0] tile_count_r;
  logic [osah_pkg::LT_W-1:0] last_tokens_r;
  osah_pkg::osah_entry_t     fifo_r [DEPTH];
  logic [1:0]                wr_ptr_r;
  logic [1:0]                rd_ptr_r;
  logic [2:0]                cnt_r;
  osah_pkg::osah_entry_t     cls;
  logic                      accept;
  logic                      push;
  logic                      dim_ok;
  logic                      tok_ok;
  logic                      full_tile;

  always_comb begin
    dim_ok    = 32'(in_dim_index) < HEAD_SIZE;
    tok_ok    = 32'(in_token_index) < TILE_TOKENS;
    full_tile = (tile_count_r != '0) &&
                ((11'(in_tile_index) + 11'd1) < tile_count_r);
    cls.dim    = in_dim_index;
    cls.tok    = in_token_index;
    cls.q      = in_q_elem;
    cls.k      = in_k_elem;
    cls.v      = in_v_elem;
    cls.dim_ok = dim_ok;
    if (full_tile || (32'(last_tokens_r) > TILE_TOKENS)) begin
      cls.cnt = osah_pkg::CNT_W'(TILE_TOKENS);
    end else begin
      cls.cnt = osah_pkg::CNT_W'(last_tokens_r);
    end
    case (in_command)
      osah_pkg::CMD_CLEAR:   cls.op = osah_pkg::OP_CLEAR;
      osah_pkg::CMD_LOAD_Q:  cls.op = dim_ok ? osah_pkg::OP_LOAD_Q : osah_pkg::OP_NOP;
      osah_pkg::CMD_LOAD_KV: cls.op = (dim_ok && tok_ok) ? osah_pkg::OP_LOAD_KV
                                                         : osah_pkg::OP_NOP;
      osah_pkg::CMD_TILE:    cls.op = osah_pkg::OP_TILE;
      osah_pkg::CMD_READ:    cls.op = osah_pkg::OP_READ;
      default:               cls.op = osah_pkg::OP_NOP;
    endcase
  end

  assign busy   = (cnt_r == 3'(DEPTH));
  assign accept = start && !busy;
  // Dropped commands are accepted but never reach the queue.
  assign push   = accept && (cls.op != osah_pkg::OP_NOP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_count_r  <= osah_pkg::TC_W'(1);
      last_tokens_r <= osah_pkg::LT_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        osah_pkg::REG_TILE_COUNT:  tile_count_r  <= cfg_wdata[osah_pkg::TC_W-1:0];
        osah_pkg::REG_LAST_TOKENS: last_tokens_r <= cfg_wdata[osah_pkg::LT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (entry_pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      case ({push, entry_pop})
        2'b10:   cnt_r <= cnt_r + 3'd1;
        2'b01:   cnt_r <= cnt_r - 3'd1;
        default: ;
      endcase
    end
  end

  assign entry       = fifo_r[rd_ptr_r];
  assign entry_valid = (cnt_r != '0);

endmodule

`default_nettype wire

FILE: src/osah_back.sv
// ----------------------------------------------------------------------------
// osah_back: execution engine
// Owns the query, key/value and accumulator memories, scores tiles with a
// shared multiply-accumulate, runs the online softmax update and divides out
// normalised results.
// ----------------------------------------------------------------------------
`default_nettype none

module osah_back #(
  parameter int HEAD_SIZE   = osah_pkg::HEAD_SIZE_DEF,
  parameter int TILE_TOKENS = osah_pkg::TILE_TOKENS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire osah_pkg::osah_entry_t entry,
  input  wire logic                  entry_valid,
  output logic                       entry_pop,
  output logic                       out_strobe,
  output logic signed [15:0]         out_elem,
  output logic [6:0]                 out_dim
);

  localparam int HA    = $clog2(HEAD_SIZE);
  localparam int DW    = $clog2(HEAD_SIZE + 1);
  localparam int TA    = (TILE_TOKENS > 1) ? $clog2(TILE_TOKENS) : 1;
  localparam int TW    = $clog2(TILE_TOKENS + 1);
  localparam int KN    = TILE_TOKENS * HEAD_SIZE;
  localparam int KA    = $clog2(KN);
  localparam int DOTW  = 32 + HA;
  localparam int SCW   = DOTW + 23;
  localparam int LSW   = 17 + TW;
  localparam int CW    = osah_pkg::CNT_W;

  localparam logic signed [SCW-1:0] SCALE_S = SCW'(osah_pkg::SCALE_Q24);
  localparam logic signed [SCW-1:0] HALF31  = SCW'(64'h8000_0000);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCORE   = 4'd1;
  localparam logic [3:0] S_MAX     = 4'd2;
  localparam logic [3:0] S_OSCALE  = 4'd3;
  localparam logic [3:0] S_RESCALE = 4'd4;
  localparam logic [3:0] S_WEIGHT  = 4'd5;
  localparam logic [3:0] S_ACC     = 4'd6;
  localparam logic [3:0] S_FINISH  = 4'd7;
  localparam logic [3:0] S_RD      = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;

  // Memories
  logic signed [15:0] q_mem   [HEAD_SIZE];
  logic signed [15:0] k_mem   [KN];
  logic signed [15:0] v_mem   [KN];
  logic signed [47:0] acc_mem [HEAD_SIZE];
  logic signed [15:0] q_rd_r;
  logic signed [15:0] k_rd_r;
  logic signed [15:0] v_rd_r;
  logic signed [47:0] acc_rd_r;
  logic [HEAD_SIZE-1:0] acc_vld_r;

  // Control
  logic [3:0]    state_r;
  logic [2:0]    sub_r;
  logic [DW-1:0] d_r;
  logic [TW-1:0] t_r;
  logic [KA-1:0] addr_r;
  logic [CW-1:0] cnt_r;
  logic          out_strobe_r;

  // Datapath
  logic signed [DOTW-1:0] dot_r;
  logic signed [31:0]     prod_r;
  logic signed [SCW-1:0]  scaled_r;
  logic signed [31:0]     score_r [TILE_TOKENS];
  logic signed [31:0]     lmax_r;
  logic signed [31:0]     run_max_r;
  logic signed [31:0]     new_max_r;
  logic [39:0]            run_sum_r;
  logic [39:0]            rsum_scaled_r;
  logic [LSW-1:0]         lsum_r;
  logic [16:0]            scale_r;
  logic [16:0]            w_r;
  logic signed [47:0]     a_r;
  logic [40:0]            plo_r;
  logic signed [41:0]     phi_r;
  logic signed [33:0]     wv_r;
  logic                   neg_r;
  logic [48:0]            quo_r;
  logic [39:0]            rem_r;
  logic [5:0]             div_cnt_r;
  logic signed [15:0]     out_elem_r;
  logic [6:0]             out_dim_r;

  // Combinational helpers
  logic               at_sum;
  logic               acc_hit;
  logic signed [47:0] acc_cur;
  logic signed [47:0] a_sel;
  logic signed [65:0] rs;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_sat;
  logic signed [SCW-1:0] rnd;
  logic signed [31:0] score_new;
  logic               acc_we;
  logic signed [47:0] acc_wd;
  logic               exp_start;
  logic signed [32:0] exp_x;
  logic               exp_done;
  logic [16:0]        exp_y;
  logic [40:0]        rem_sh;
  logic               q_bit;
  logic [47:0]        mag;
  logic [40:0]        sum_new;
  logic               row_last;
  logic               tok_last;

  always_comb begin
    at_sum   = (32'(d_r) == HEAD_SIZE);
    acc_hit  = acc_vld_r[d_r[HA-1:0]];
    acc_cur  = acc_hit ? acc_rd_r : 48'sd0;
    a_sel    = at_sum ? $signed(48'(run_sum_r)) : acc_cur;
    rs       = $signed({phi_r, 24'b0}) + $signed({25'b0, plo_r}) + 66'sd32768;
    acc_sum  = 49'(acc_cur) + 49'(wv_r);
    if (acc_sum[48] != acc_sum[47]) begin
      acc_sat = {acc_sum[48], {47{~acc_sum[48]}}};
    end else begin
      acc_sat = acc_sum[47:0];
    end
    rnd       = scaled_r + HALF31;
    score_new = 32'($signed(rnd[SCW-1:32]));
    row_last  = (32'(d_r) == HEAD_SIZE - 1);
    tok_last  = (32'(t_r) + 1 == 32'(cnt_r));
    acc_we    = (state_r == S_RESCALE && sub_r == 3'd3 && !at_sum) ||
                (state_r == S_ACC && sub_r == 3'd2);
    acc_wd    = (state_r == S_ACC) ? acc_sat : rs[63:16];
    exp_start = (state_r == S_OSCALE && sub_r == 3'd0 && run_sum_r != '0) ||
                (state_r == S_WEIGHT && sub_r == 3'd0);
    if (state_r == S_WEIGHT) begin
      exp_x = 33'(score_r[t_r[TA-1:0]]) - 33'(new_max_r);
    end else begin
      exp_x = 33'(run_max_r) - 33'(new_max_r);
    end
    rem_sh  = {rem_r, quo_r[48]};
    q_bit   = (rem_sh >= {1'b0, run_sum_r});
    mag     = acc_cur[47] ? 48'(-acc_cur) : 48'(acc_cur);
    sum_new = 41'(rsum_scaled_r) + 41'(lsum_r);
  end

  osah_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start),
    .x     (exp_x),
    .done  (exp_done),
    .y     (exp_y)
  );

  assign entry_pop = (state_r == S_IDLE) && entry_valid;

  // Memory ports: one write, one registered read each.
  always_ff @(posedge clk) begin
    if (entry_pop && entry.op == osah_pkg::OP_LOAD_Q) begin
      q_mem[HA'(entry.dim)] <= entry.q;
    end
    q_rd_r <= q_mem[d_r[HA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (entry_pop && entry.op == osah_pkg::OP_LOAD_KV) begin
      k_mem[KA'(32'(entry.tok) * HEAD_SIZE + 32'(entry.dim))] <= entry.k;
    end
    k_rd_r <= k_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (entry_pop && entry.op == osah_pkg::OP_LOAD_KV) begin
      v_mem[KA'(32'(entry.tok) * HEAD_SIZE + 32'(entry.dim))] <= entry.v;
    end
    v_rd_r <= v_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[d_r[HA-1:0]] <= acc_wd;
    end
    acc_rd_r <= acc_mem[d_r[HA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sub_r        <= '0;
      out_strobe_r <= 1'b0;
      acc_vld_r    <= '0;
      run_max_r    <= osah_pkg::SCORE_MIN;
      run_sum_r    <= '0;
    end else begin
      out_strobe_r <= 1'b0;
      if (acc_we) begin
        acc_vld_r[d_r[HA-1:0]] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (entry_valid) begin
            case (entry.op)
              osah_pkg::OP_CLEAR: begin
                acc_vld_r <= '0;
                run_max_r <= osah_pkg::SCORE_MIN;
                run_sum_r <= '0;
              end
              osah_pkg::OP_TILE: begin
                cnt_r  <= entry.cnt;
                t_r    <= '0;
                d_r    <= '0;
                addr_r <= '0;
                dot_r  <= '0;
                sub_r  <= '0;
                lmax_r <= osah_pkg::SCORE_MIN;
                state_r <= (entry.cnt == '0) ? S_MAX : S_SCORE;
              end
              osah_pkg::OP_READ: begin
                out_dim_r <= entry.dim;
                if (!entry.dim_ok || run_sum_r == '0) begin
                  out_elem_r   <= '0;
                  out_strobe_r <= 1'b1;
                end else begin
                  d_r     <= DW'(entry.dim);
                  sub_r   <= '0;
                  state_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCORE: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: begin
              prod_r <= 32'(q_rd_r) * 32'(k_rd_r);
              sub_r  <= 3'd2;
            end
            3'd2: begin
              dot_r  <= dot_r + DOTW'(prod_r);
              addr_r <= addr_r + KA'(1);
              if (row_last) begin
                d_r   <= '0;
                sub_r <= 3'd3;
              end else begin
                d_r   <= d_r + DW'(1);
                sub_r <= 3'd0;
              end
            end
            3'd3: begin
              scaled_r <= SCW'(dot_r) * SCALE_S;
              sub_r    <= 3'd4;
            end
            default: begin
              score_r[t_r[TA-1:0]] <= score_new;
              if (score_new > lmax_r) begin
                lmax_r <= score_new;
              end
              dot_r <= '0;
              t_r   <= t_r + TW'(1);
              sub_r <= 3'd0;
              if (tok_last) begin
                state_r <= S_MAX;
              end
            end
          endcase
        end

        S_MAX: begin
          new_max_r <= (run_max_r > lmax_r) ? run_max_r : lmax_r;
          sub_r     <= '0;
          state_r   <= S_OSCALE;
        end

        S_OSCALE: begin
          if (sub_r == 3'd0) begin
            if (run_sum_r == '0) begin
              scale_r <= '0;
              d_r     <= '0;
              state_r <= S_RESCALE;
            end else begin
              sub_r <= 3'd1;
            end
          end else if (exp_done) begin
            scale_r <= exp_y;
            d_r     <= '0;
            sub_r   <= '0;
            state_r <= S_RESCALE;
          end
        end

        S_RESCALE: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: begin
              a_r   <= a_sel;
              plo_r <= a_sel[23:0] * scale_r;
              sub_r <= 3'd2;
            end
            3'd2: begin
              phi_r <= $signed(a_r[47:24]) * $signed({1'b0, scale_r});
              sub_r <= 3'd3;
            end
            default: begin
              sub_r <= 3'd0;
              if (at_sum) begin
                rsum_scaled_r <= rs[55:16];
                lsum_r        <= '0;
                t_r           <= '0;
                d_r           <= '0;
                addr_r        <= '0;
                state_r       <= (cnt_r == '0) ? S_FINISH : S_WEIGHT;
              end else begin
                d_r <= d_r + DW'(1);
              end
            end
          endcase
        end

        S_WEIGHT: begin
          if (sub_r == 3'd0) begin
            sub_r <= 3'd1;
          end else if (exp_done) begin
            w_r     <= exp_y;
            lsum_r  <= lsum_r + LSW'(exp_y);
            d_r     <= '0;
            sub_r   <= '0;
            state_r <= S_ACC;
          end
        end

        S_ACC: begin
          case (sub_r)
            3'd0: sub_r <= 3'd1;
            3'd1: begin
              wv_r  <= $signed({1'b0, w_r}) * v_rd_r;
              sub_r <= 3'd2;
            end
            default: begin
              addr_r <= addr_r + KA'(1);
              sub_r  <= 3'd0;
              if (row_last) begin
                d_r <= '0;
                t_r <= t_r + TW'(1);
                state_r <= tok_last ? S_FINISH : S_WEIGHT;
              end else begin
                d_r <= d_r + DW'(1);
              end
            end
          endcase
        end

        S_FINISH: begin
          run_max_r <= new_max_r;
          run_sum_r <= sum_new[40] ? {40{1'b1}} : sum_new[39:0];
          state_r   <= S_IDLE;
        end

        S_RD: begin
          if (sub_r == 3'd0) begin
            sub_r <= 3'd1;
          end else begin
            neg_r     <= acc_cur[47];
            quo_r     <= 49'(mag) + 49'(run_sum_r >> 1);
            rem_r     <= '0;
            div_cnt_r <= 6'd49;
            state_r   <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_cnt_r != '0) begin
            rem_r     <= q_bit ? 40'(rem_sh - {1'b0, run_sum_r}) : rem_sh[39:0];
            quo_r     <= {quo_r[47:0], q_bit};
            div_cnt_r <= div_cnt_r - 6'd1;
          end else begin
            if (neg_r) begin
              out_elem_r <= (quo_r >= 49'd32768) ? -16'sd32768 : -$signed(quo_r[15:0]);
            end else begin
              out_elem_r <= (quo_r >= 49'd32767) ? 16'sd32767 : $signed(quo_r[15:0]);
            end
            out_strobe_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_elem   = out_elem_r;
  assign out_dim    = out_dim_r;

  a_div_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (run_sum_r != '0))
    else $error("division started with an empty running sum");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !entry_valid) |=> !out_strobe_r)
    else $error("result produced without a read transaction");

  a_exp_owner: assert property (@(posedge clk) disable iff (!rst_n)
    exp_done |-> (state_r == S_OSCALE || state_r == S_WEIGHT))
    else $error("exponential finished outside a phase that waits for it");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |=> (state_r == S_IDLE && run_max_r == $past(new_max_r)))
    else $error("tile update did not commit the new maximum");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the online-softmax attention head
// Drives clear, load, tile and read transactions through the start/busy port,
// rewrites the tile configuration between phases and checks every returned
// output element against an in-bench fixed-point predictor of the head.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  // Commands the head does not know; they must be swallowed without a result.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int  HEADS       = 128;
  localparam int  TOKENS      = 16;
  localparam int  CYCLE_LIMIT = 3_000_000;
  localparam int  TAIL_CYCLES = 80;
  localparam longint ACC_TOP  = 64'sd140737488355327;
  localparam longint ACC_BOT  = -64'sd140737488355328;
  localparam longint unsigned SUM_TOP = 64'd1099511627775;

  typedef struct {
    logic [2:0]         cmd;
    logic [6:0]         dim;
    logic [3:0]         tok;
    logic signed [15:0] q;
    logic signed [15:0] k;
    logic signed [15:0] v;
    logic [9:0]         tidx;
  } head_cmd_t;

  typedef struct {
    logic signed [15:0] elem;
    logic [6:0]         dim;
  } out_elem_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [2:0]                 in_command;
  logic [6:0]                 in_dim_index;
  logic [3:0]                 in_token_index;
  logic signed [15:0]         in_q_elem;
  logic signed [15:0]         in_k_elem;
  logic signed [15:0]         in_v_elem;
  logic [9:0]                 in_tile_index;
  logic                       cfg_we;
  logic [0:0]                 cfg_index;
  logic [osah_pkg::CFG_W-1:0] cfg_wdata;
  logic                       out_strobe;
  logic signed [15:0]         out_elem;
  logic [6:0]                 out_dim;

  online_softmax_attention_head_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_dim_index(in_dim_index),
    .in_token_index(in_token_index), .in_q_elem(in_q_elem),
    .in_k_elem(in_k_elem), .in_v_elem(in_v_elem),
    .in_tile_index(in_tile_index), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .out_strobe(out_strobe), .out_elem(out_elem),
    .out_dim(out_dim)
  );

  always #5 clk = ~clk;

  // Shadow of the head: stores, accumulator, running statistics and config.
  logic signed [15:0] query_mem [HEADS];
  logic signed [15:0] key_mem   [HEADS*TOKENS];
  logic signed [15:0] value_mem [HEADS*TOKENS];
  longint             accum     [HEADS];
  longint             max_score;
  longint unsigned    weight_sum;
  int                 tile_total;
  int                 last_tokens;

  out_elem_t pending_outputs[$];
  int        mismatches;
  int        cycle_count;
  bit        idling_on;

  // Exponential of a non-positive Q.16 argument: (1 + x/64)^64, zero at -16.
  function automatic longint unsigned softmax_weight(longint x);
    longint unsigned y;
    if (x <= -(64'sd16 * 64'sd65536)) return 0;
    if (x > 0) x = 0;
    y = 64'(65536 + (x >>> 6));
    repeat (6) y = (y * y + 64'd32768) >> 16;
    return y;
  endfunction

  function automatic void fold_tile(logic [9:0] tidx);
    int              valid;
    longint          dot, sc, tile_peak, new_max, prod;
    longint          scores [TOKENS];
    longint unsigned rescale, tile_sum, w, s;
    if (int'(tidx) < tile_total - 1) valid = TOKENS;
    else valid = (last_tokens > TOKENS) ? TOKENS : last_tokens;
    tile_peak = -64'sd2147483648;
    tile_sum = 0;
    for (int t = 0; t < valid; t++) begin
      dot = 0;
      for (int d = 0; d < HEADS; d++)
        dot += longint'(query_mem[d]) * longint'(key_mem[t*HEADS+d]);
      sc = (dot * longint'(osah_pkg::SCALE_Q24) + 64'sd2147483648) >>> 32;
      if (sc > 64'sd2147483647) sc = 64'sd2147483647;
      if (sc < -64'sd2147483648) sc = -64'sd2147483648;
      scores[t] = sc;
      if (sc > tile_peak) tile_peak = sc;
    end
    new_max = (max_score > tile_peak) ? max_score : tile_peak;
    rescale = (weight_sum == 0) ? 0 : softmax_weight(max_score - new_max);
    for (int d = 0; d < HEADS; d++)
      accum[d] = (accum[d] * longint'(rescale) + 64'sd32768) >>> 16;
    for (int t = 0; t < valid; t++) begin
      w = softmax_weight(scores[t] - new_max);
      tile_sum += w;
      for (int d = 0; d < HEADS; d++) begin
        prod = accum[d] + longint'(w) * longint'(value_mem[t*HEADS+d]);
        if (prod > ACC_TOP) prod = ACC_TOP;
        if (prod < ACC_BOT) prod = ACC_BOT;
        accum[d] = prod;
      end
    end
    max_score = new_max;
    s = ((weight_sum * rescale + 64'd32768) >> 16) + tile_sum;
    weight_sum = (s > SUM_TOP) ? SUM_TOP : s;
  endfunction

  function automatic logic signed [15:0] normalised_elem(logic [6:0] dim);
    longint          a;
    longint unsigned mag, quo;
    if (weight_sum == 0) return '0;
    a = accum[dim];
    mag = (a < 0) ? longint'(-a) : a;
    quo = (mag + weight_sum / 2) / weight_sum;
    if (a < 0) return (quo >= 32768) ? 16'sh8000 : -16'(quo);
    return (quo >= 32767) ? 16'sh7fff : 16'(quo);
  endfunction

  function automatic void clear_running();
    foreach (accum[d]) accum[d] = 0;
    max_score  = -64'sd2147483648;
    weight_sum = 0;
  endfunction

  // Applies one accepted transaction to the shadow and queues any output.
  function automatic void predict_head(head_cmd_t c);
    out_elem_t r;
    case (c.cmd)
      osah_pkg::CMD_CLEAR:   clear_running();
      osah_pkg::CMD_LOAD_Q:  query_mem[c.dim] = c.q;
      osah_pkg::CMD_LOAD_KV: begin
        key_mem[c.tok*HEADS+c.dim]   = c.k;
        value_mem[c.tok*HEADS+c.dim] = c.v;
      end
      osah_pkg::CMD_TILE:    fold_tile(c.tidx);
      osah_pkg::CMD_READ: begin
        r.elem = normalised_elem(c.dim);
        r.dim  = c.dim;
        pending_outputs.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Element values lean towards small magnitudes so that several tokens of a
  // tile keep a non-zero weight; full-range and extreme values still appear.
  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      2:       return 16'($signed($urandom_range(0, 8191)) - 4096);
      default: return 16'($signed($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  function automatic head_cmd_t noise_cmd(logic [2:0] cmd);
    head_cmd_t c;
    c.cmd  = cmd;
    c.dim  = 7'($urandom);
    c.tok  = 4'($urandom);
    c.q    = 16'($urandom);
    c.k    = 16'($urandom);
    c.v    = 16'($urandom);
    c.tidx = 10'($urandom);
    return c;
  endfunction

  // Every call starts and ends just after a rising edge.
  task automatic send_cmd(head_cmd_t c);
    start          <= 1'b1;
    in_command     <= c.cmd;
    in_dim_index   <= c.dim;
    in_token_index <= c.tok;
    in_q_elem      <= c.q;
    in_k_elem      <= c.k;
    in_v_elem      <= c.v;
    in_tile_index  <= c.tidx;
    do @(posedge clk); while (busy);
    predict_head(c);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Always lets at least one edge pass, so start is never driven twice at once.
  task automatic wait_outputs_done();
    start <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
  endtask

  // A read queued behind everything else proves the head has gone idle once
  // its output arrives, since transactions execute in order.
  task automatic write_reg(logic [0:0] idx, int value);
    head_cmd_t c;
    c = noise_cmd(osah_pkg::CMD_READ);
    send_cmd(c);
    wait_outputs_done();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= osah_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == osah_pkg::REG_TILE_COUNT) tile_total = value & 32'h7ff;
    else last_tokens = value & 32'h1f;
  endtask

  task automatic read_dim(logic [6:0] dim);
    head_cmd_t c;
    c = noise_cmd(osah_pkg::CMD_READ);
    c.dim = dim;
    send_cmd(c);
  endtask

  task automatic run_tile(logic [9:0] tidx);
    head_cmd_t c;
    c = noise_cmd(osah_pkg::CMD_TILE);
    c.tidx = tidx;
    send_cmd(c);
  endtask

  // Every store entry is written once before any tile, so no tile ever looks
  // at an entry that was never loaded. The first entries take the extremes.
  task automatic test_fill_stores();
    head_cmd_t c;
    for (int d = 0; d < HEADS; d++) begin
      c = noise_cmd(osah_pkg::CMD_LOAD_Q);
      c.dim = 7'(d);
      c.q   = (d == 0) ? 16'sh8000 : (d == 1) ? 16'sh7fff : rand_elem();
      send_cmd(c);
    end
    for (int i = 0; i < HEADS*TOKENS; i++) begin
      c = noise_cmd(osah_pkg::CMD_LOAD_KV);
      c.dim = 7'(i % HEADS);
      c.tok = 4'(i / HEADS);
      c.k   = (i == 0) ? 16'sh8000 : (i == 1) ? 16'sh7fff : rand_elem();
      c.v   = (i == 0) ? 16'sh7fff : (i == 1) ? 16'sh8000 : rand_elem();
      send_cmd(c);
    end
  endtask

  // Directed corner cases: empty sum, unknown commands, zero and oversized
  // token counts, a zero tile count, the widest tile count and clear.
  task automatic test_corners();
    read_dim(7'd0);
    read_dim(7'd127);
    send_cmd(noise_cmd(CMD_SPARE_5));
    send_cmd(noise_cmd(CMD_SPARE_6));
    send_cmd(noise_cmd(CMD_SPARE_7));
    run_tile(10'd0);
    read_dim(7'd0);
    read_dim(7'd0);
    read_dim(7'd127);
    write_reg(osah_pkg::REG_LAST_TOKENS, 0);
    run_tile(10'd0);
    read_dim(7'd1);
    send_cmd(noise_cmd(osah_pkg::CMD_CLEAR));
    read_dim(7'd1);
    write_reg(osah_pkg::REG_LAST_TOKENS, 31);
    run_tile(10'd1023);
    read_dim(7'd64);
    write_reg(osah_pkg::REG_TILE_COUNT, 0);
    write_reg(osah_pkg::REG_LAST_TOKENS, 3);
    run_tile(10'd512);
    read_dim(7'd2);
    write_reg(osah_pkg::REG_TILE_COUNT, 2047);
    run_tile(10'd1023);
    read_dim(7'd127);
  endtask

  // One configuration phase of random traffic: mostly loads and reads with
  // an occasional tile, clear or unknown command.
  task automatic test_random_phase(int tc, int lt, int items, bit hold_off);
    head_cmd_t c;
    int        pick;
    write_reg(osah_pkg::REG_TILE_COUNT, tc);
    write_reg(osah_pkg::REG_LAST_TOKENS, lt);
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      c = noise_cmd(osah_pkg::CMD_LOAD_KV);
      else if (pick < 50) c = noise_cmd(osah_pkg::CMD_LOAD_Q);
      else if (pick < 85) c = noise_cmd(osah_pkg::CMD_READ);
      else if (pick < 90) begin
        c = noise_cmd(osah_pkg::CMD_TILE);
        if ($urandom_range(0, 1) != 0)
          c.tidx = (tc == 0) ? 10'd0 : 10'((tc > 1024 ? 1024 : tc) - 1);
      end
      else if (pick < 93) c = noise_cmd(osah_pkg::CMD_CLEAR);
      else if (pick < 96) c = noise_cmd(3'($urandom_range(5, 7)));
      else                c = noise_cmd(osah_pkg::CMD_READ);
      if (c.cmd == osah_pkg::CMD_LOAD_Q) c.q = rand_elem();
      if (c.cmd == osah_pkg::CMD_LOAD_KV) begin
        c.k = rand_elem();
        c.v = rand_elem();
      end
      send_cmd(c);
      if (hold_off && n == items / 2) wait_outputs_done();
    end
  endtask

  // Results cannot be held off, so each strobe is checked at the edge that
  // ends its cycle against the oldest outstanding prediction.
  out_elem_t want;
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: elem %0d dim %0d", out_elem, out_dim);
      end else begin
        want = pending_outputs.pop_front();
        if (out_elem !== want.elem || out_dim !== want.dim) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected elem %0d dim %0d, got elem %0d dim %0d",
                     want.elem, want.dim, out_elem, out_dim);
        end
      end
    end
  end

  // Watchdog: generous against the slowest legal run, dominated by tiles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_command     <= osah_pkg::CMD_CLEAR;
    in_dim_index   <= '0;
    in_token_index <= '0;
    in_q_elem      <= '0;
    in_k_elem      <= '0;
    in_v_elem      <= '0;
    in_tile_index  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= osah_pkg::REG_TILE_COUNT;
    cfg_wdata      <= '0;
    mismatches  = 0;
    cycle_count = 0;
    idling_on   = 1'b1;
    tile_total  = 1;
    last_tokens = 16;
    clear_running();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_stores();
    test_corners();
    test_random_phase(1, 16, 60, 1'b0);
    test_random_phase(3, 5, 60, 1'b1);
    test_random_phase(1024, 16, 60, 1'b0);
    test_random_phase(0, 0, 50, 1'b0);
    test_random_phase(2047, 31, 60, 1'b0);
    // Closing stretch runs back to back with no idling at all.
    idling_on = 1'b0;
    test_random_phase(2, 1, 60, 1'b0);
    read_dim(7'($urandom));

    wait_outputs_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/osah_pkg.sv
src/osah_exp.sv
src/osah_front.sv
src/osah_back.sv
src/online_softmax_attention_head_top.sv
tb/tb_top.sv
